// ===== src/imu_report_field_parser_core_assert.svh =====
// Assertion macros used by the checker file of the report field parser.
`ifndef IMU_REPORT_FIELD_PARSER_CORE_ASSERT_SVH
`define IMU_REPORT_FIELD_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define IRFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("report field parser check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define IRFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("report field parser check failed");

`endif

// ===== src/imu_rfp_pkg.sv =====
// Types, constants and section tables of the report field parser.
`timescale 1ns / 1ps

package imu_rfp_pkg;

  localparam logic [7:0] TYPE_BYTE    = 8'h11;
  localparam logic [6:0] COUNT_MAX    = 7'd127;
  localparam logic [3:0] NUM_SECTIONS = 4'd12;
  localparam logic [3:0] EULER_SEC    = 4'd6;

  localparam logic [4:0] FID_TIMESTAMP = 5'd0;
  localparam logic [4:0] FID_TEMP      = 5'd13;
  localparam logic [4:0] FID_PRESSURE  = 5'd14;
  localparam logic [4:0] FID_HEIGHT    = 5'd15;
  localparam logic [4:0] FID_EULER_COR = 5'd23;
  localparam logic [4:0] FID_VOLTAGE   = 5'd29;

  typedef enum logic [1:0] {
    KIND_VEC  = 2'd0,
    KIND_ENV  = 2'd1,
    KIND_SKIP = 2'd2,
    KIND_VOLT = 2'd3
  } sec_kind_t;

  // One queued unit of work: a single field, or the third Euler angle
  // followed by its three corrected angles.
  typedef struct packed {
    logic [4:0]         field_id;
    logic signed [32:0] value;
    logic               euler;
    logic [2:0][16:0]   corr;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  function automatic logic [3:0] sec_len(input logic [3:0] s);
    logic [3:0] r;
    case (s)
      4'd4, 4'd5: r = 4'd8;
      4'd8:       r = 4'd5;
      4'd10:      r = 4'd2;
      4'd11:      r = 4'd1;
      default:    r = 4'd6;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] sec_base(input logic [3:0] s);
    logic [4:0] r;
    case (s)
      4'd0:    r = 5'd1;
      4'd1:    r = 5'd4;
      4'd2:    r = 5'd7;
      4'd3:    r = 5'd10;
      4'd4:    r = 5'd13;
      4'd5:    r = 5'd16;
      4'd6:    r = 5'd20;
      4'd7:    r = 5'd26;
      4'd10:   r = 5'd29;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic sec_kind_t sec_kind(input logic [3:0] s);
    sec_kind_t r;
    case (s)
      4'd4:              r = KIND_ENV;
      4'd8, 4'd9, 4'd11: r = KIND_SKIP;
      4'd10:             r = KIND_VOLT;
      default:           r = KIND_VEC;
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] sext16(input logic [15:0] x);
    return {{17{x[15]}}, x};
  endfunction

  function automatic logic signed [32:0] sext24(input logic [23:0] x);
    return {{9{x[23]}}, x};
  endfunction

endpackage

// ===== src/imu_rfp_front.sv =====
// Front end: accepts bytes, tracks packet and section state, queues field work.
`timescale 1ns / 1ps

module imu_rfp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_start_code,
  input  logic                 in_accept,
  input  logic                 in_func,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_end_of_packet,
  output imu_rfp_pkg::push_t   push
);
  import imu_rfp_pkg::*;

  logic [7:0]  start_code_r;
  logic [6:0]  byte_count_r, byte_count_nxt;
  logic        accepted_r, accepted_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [3:0]  sec_r, sec_nxt;
  logic [3:0]  bis_r, bis_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [2:0][15:0] last_euler_r, last_euler_nxt;
  logic [2:0][15:0] offset_r, offset_nxt;

  logic [3:0]  found;
  logic [3:0]  bis_inc;
  logic [1:0]  pos;
  logic [1:0]  vec_idx;
  logic [31:0] asm_new;

  function automatic logic [31:0] merge(input logic [31:0] a, input logic [7:0] b,
                                        input logic [1:0] p);
    return a | ({24'd0, b} << {p, 3'b000});
  endfunction

  function automatic logic [16:0] diff(input logic [15:0] a, input logic [15:0] o);
    return {a[15], a} - {o[15], o};
  endfunction

  // First enabled section at or after the current one; twelve means none left.
  always_comb begin
    found = NUM_SECTIONS;
    for (int i = 11; i >= 0; i--) begin
      if (tag_r[i] && (4'(i) >= sec_r)) begin
        found = 4'(i);
      end
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    accepted_nxt   = accepted_r;
    tag_nxt        = tag_r;
    sec_nxt        = sec_r;
    bis_nxt        = bis_r;
    asm_nxt        = asm_r;
    last_euler_nxt = last_euler_r;
    offset_nxt     = offset_r;
    push           = '0;
    pos            = 2'd0;
    vec_idx        = bis_r[2:1];
    bis_inc        = bis_r + 4'd1;
    asm_new        = asm_r;

    if (in_accept && in_func) begin
      offset_nxt = last_euler_r;
    end else if (in_accept) begin
      if (byte_count_r == 7'd0) begin
        accepted_nxt = (in_rx_byte == start_code_r);
      end else if (byte_count_r == 7'd3) begin
        if (in_rx_byte != TYPE_BYTE) begin
          accepted_nxt = 1'b0;
        end
      end else if (accepted_r && byte_count_r >= 7'd4) begin
        if (byte_count_r == 7'd4) begin
          tag_nxt[7:0] = in_rx_byte;
          sec_nxt      = 4'd0;
          bis_nxt      = 4'd0;
          asm_nxt      = 32'd0;
        end else if (byte_count_r == 7'd5) begin
          tag_nxt[15:8] = in_rx_byte;
        end else if (byte_count_r <= 7'd9) begin
          pos     = 2'(byte_count_r - 7'd6);
          asm_new = merge(asm_r, in_rx_byte, pos);
          asm_nxt = asm_new;
          if (byte_count_r == 7'd9) begin
            push.valid          = 1'b1;
            push.job.field_id   = FID_TIMESTAMP;
            push.job.value      = {1'b0, asm_new};
            asm_nxt             = 32'd0;
          end
        end else begin
          sec_nxt = found;
          if (found < NUM_SECTIONS) begin
            case (sec_kind(found))
              KIND_VEC: begin
                pos     = {1'b0, bis_r[0]};
                asm_new = merge(asm_r, in_rx_byte, pos);
                asm_nxt = asm_new;
                if (bis_r[0]) begin
                  push.valid        = 1'b1;
                  push.job.field_id = sec_base(found) + {3'd0, vec_idx};
                  push.job.value    = sext16(asm_new[15:0]);
                  asm_nxt           = 32'd0;
                  if (found == EULER_SEC && vec_idx != 2'd3) begin
                    last_euler_nxt[vec_idx] = asm_new[15:0];
                    if (vec_idx == 2'd2) begin
                      push.job.euler   = 1'b1;
                      push.job.corr[0] = diff(last_euler_r[0], offset_r[0]);
                      push.job.corr[1] = diff(last_euler_r[1], offset_r[1]);
                      push.job.corr[2] = diff(asm_new[15:0], offset_r[2]);
                    end
                  end
                end
              end
              KIND_ENV: begin
                if (bis_r < 4'd2) begin
                  pos     = {1'b0, bis_r[0]};
                  asm_new = merge(asm_r, in_rx_byte, pos);
                  asm_nxt = asm_new;
                  if (bis_r == 4'd1) begin
                    push.valid        = 1'b1;
                    push.job.field_id = FID_TEMP;
                    push.job.value    = sext16(asm_new[15:0]);
                    asm_nxt           = 32'd0;
                  end
                end else begin
                  pos     = (bis_r < 4'd5) ? 2'(bis_r - 4'd2) : 2'(bis_r - 4'd5);
                  asm_new = merge(asm_r, in_rx_byte, pos);
                  asm_nxt = asm_new;
                  if (pos == 2'd2) begin
                    push.valid        = 1'b1;
                    push.job.field_id = (bis_r < 4'd5) ? FID_PRESSURE : FID_HEIGHT;
                    push.job.value    = sext24(asm_new[23:0]);
                    asm_nxt           = 32'd0;
                  end
                end
              end
              KIND_VOLT: begin
                pos     = {1'b0, bis_r[0]};
                asm_new = merge(asm_r, in_rx_byte, pos);
                asm_nxt = asm_new;
                if (bis_r == 4'd1) begin
                  push.valid        = 1'b1;
                  push.job.field_id = FID_VOLTAGE;
                  push.job.value    = {17'd0, asm_new[15:0]};
                  asm_nxt           = 32'd0;
                end
              end
              default: begin
              end
            endcase
            if (bis_inc >= sec_len(found)) begin
              sec_nxt = found + 4'd1;
              bis_nxt = 4'd0;
            end else begin
              bis_nxt = bis_inc;
            end
          end
        end
      end

      if (byte_count_r != COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 7'd1;
      end
      if (in_end_of_packet) begin
        byte_count_nxt = 7'd0;
        accepted_nxt   = 1'b0;
        sec_nxt        = 4'd0;
        bis_nxt        = 4'd0;
        asm_nxt        = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= 8'd0;
      byte_count_r <= 7'd0;
      accepted_r   <= 1'b0;
      tag_r        <= 16'd0;
      sec_r        <= 4'd0;
      bis_r        <= 4'd0;
      asm_r        <= 32'd0;
      last_euler_r <= '0;
      offset_r     <= '0;
    end else begin
      if (cfg_valid) begin
        start_code_r <= cfg_start_code;
      end
      byte_count_r <= byte_count_nxt;
      accepted_r   <= accepted_nxt;
      tag_r        <= tag_nxt;
      sec_r        <= sec_nxt;
      bis_r        <= bis_nxt;
      asm_r        <= asm_nxt;
      last_euler_r <= last_euler_nxt;
      offset_r     <= offset_nxt;
    end
  end

endmodule

// ===== src/imu_rfp_queue.sv =====
// Two-entry queue of field work between the front and back ends.
`timescale 1ns / 1ps

module imu_rfp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  imu_rfp_pkg::push_t  push,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output imu_rfp_pkg::job_t   head
);
  import imu_rfp_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/imu_rfp_back.sv =====
// Back end: expands queued work into result items through an output register.
`timescale 1ns / 1ps

module imu_rfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  imu_rfp_pkg::job_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [4:0]          out_field_id,
  output logic signed [32:0]  out_field_value,
  output logic                out_last_of_run
);
  import imu_rfp_pkg::*;

  logic               valid_r, valid_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [4:0]         id_r, id_nxt;
  logic signed [32:0] value_r, value_nxt;
  logic               last_r, last_nxt;
  logic               load;
  logic [16:0]        corr_sel;

  assign load = head_valid && (!valid_r || !out_stall);

  always_comb begin
    case (sub_r)
      2'd1:    corr_sel = head.corr[0];
      2'd2:    corr_sel = head.corr[1];
      default: corr_sel = head.corr[2];
    endcase
  end

  always_comb begin
    valid_nxt = valid_r && out_stall;
    sub_nxt   = sub_r;
    id_nxt    = id_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (sub_r == 2'd0) begin
        id_nxt    = head.field_id;
        value_nxt = head.value;
        last_nxt  = !head.euler;
      end else begin
        // Corrected angles follow the third Euler angle in order.
        id_nxt    = FID_EULER_COR + {3'd0, sub_r - 2'd1};
        value_nxt = {{16{corr_sel[16]}}, corr_sel};
        last_nxt  = (sub_r == 2'd3);
      end
      if (last_nxt) begin
        pop     = 1'b1;
        sub_nxt = 2'd0;
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_field_id    = id_r;
  assign out_field_value = value_r;
  assign out_last_of_run = last_r;

endmodule

// ===== src/imu_report_field_parser_core.sv =====
// A result is written into the work queue when its byte is accepted, then loaded into the output register.
// Throughput: one byte per cycle while the work queue has room; results leave one per
// cycle unless stalled, and a third Euler angle holds the output for its corrections.
// The input stalls only while the two-entry work queue between front and back is full.
// Synchronous active-low reset clears packet state, Euler angles, offsets and start code.
`timescale 1ns / 1ps

module imu_report_field_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_start_code,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_end_of_packet,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_field_id,
  output logic signed [32:0] out_field_value,
  output logic               out_last_of_run
);
  import imu_rfp_pkg::*;

  push_t push;
  job_t  head;
  logic  head_valid;
  logic  pop;
  logic  full;
  logic  in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_accept = in_valid && !full;

  imu_rfp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_start_code   (cfg_start_code),
    .in_accept        (in_accept),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_packet (in_end_of_packet),
    .push             (push)
  );

  imu_rfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  imu_rfp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_id    (out_field_id),
    .out_field_value (out_field_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== src/imu_rfp_checker.sv =====
// Port-level checker for the report field parser and its bind.
`timescale 1ns / 1ps
`include "imu_report_field_parser_core_assert.svh"

module imu_rfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         out_field_id,
  input logic signed [32:0] out_field_value,
  input logic               out_last_of_run
);

  // A stalled item keeps its contents.
  `IRFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_field_id) && $stable(out_field_value) && $stable(out_last_of_run))

  // Only the third Euler angle and the first two corrections leave a run open.
  `IRFP_ASSERT_NOW(a_last_flag, out_valid, out_last_of_run == !(out_field_id == 5'd22 || out_field_id == 5'd23 || out_field_id == 5'd24))

  // The corrected angles follow back to back once the run is open.
  `IRFP_ASSERT_NEXT(a_cor_seq, out_valid && !out_stall && (out_field_id == 5'd22 || out_field_id == 5'd23 || out_field_id == 5'd24), out_valid && (out_field_id == $past(out_field_id) + 5'd1))

  `IRFP_ASSERT_NOW(a_id_range, out_valid, out_field_id <= 5'd29)

endmodule

bind imu_report_field_parser_core imu_rfp_checker u_rfp_checker (.*);

// ===== tb/imu_report_field_parser_core_tb.sv =====
// Self-checking testbench for the report field parser core: directed table plus random packets.
`timescale 1ns / 1ps

module imu_report_field_parser_core_tb;
  import imu_rfp_pkg::*;

  localparam int LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int TOTAL_ITEMS = 410;

  localparam logic [4:0] FID_ACCEL    = 5'd1;
  localparam logic [4:0] FID_ACCEL_G  = 5'd4;
  localparam logic [4:0] FID_GYRO     = 5'd7;
  localparam logic [4:0] FID_MAG      = 5'd10;
  localparam logic [4:0] FID_QUAT     = 5'd16;
  localparam logic [4:0] FID_EULER    = 5'd20;
  localparam logic [4:0] FID_POSITION = 5'd26;

  typedef enum int {
    PKT_GOOD, PKT_CUT, PKT_TRAIL, PKT_BAD_START, PKT_BAD_TYPE, PKT_LONG
  } pkt_shape_t;

  typedef struct packed {
    logic [3:0] len;
    logic [4:0] base;
    sec_kind_t  kind;
  } layout_t;

  typedef struct packed {
    logic [4:0]         id;
    logic signed [32:0] value;
    logic               last;
  } field_t;

  // One input item; typed rows carry their single expected field.
  typedef struct packed {
    logic               func;
    logic [7:0]         data;
    logic               eop;
    logic               typed;
    logic [4:0]         tid;
    logic signed [32:0] tval;
  } item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_start_code = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = 1'b0;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               in_end_of_packet = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         out_field_id;
  logic signed [32:0] out_field_value;
  logic               out_last_of_run;

  imu_report_field_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_start_code   (cfg_start_code),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_packet (in_end_of_packet),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_field_id     (out_field_id),
    .out_field_value  (out_field_value),
    .out_last_of_run  (out_last_of_run)
  );

  // Predictor state.
  logic [7:0]  code_p = 8'h00;
  int          pkt_count = 0;
  logic        pkt_ok = 1'b0;
  logic [15:0] sub_tag = 16'h0000;
  int          sec_at = 0;
  int          sec_pos = 0;
  logic [31:0] acc = 32'h0;
  logic [15:0] euler_now [3] = '{16'h0, 16'h0, 16'h0};
  logic [15:0] euler_zero [3] = '{16'h0, 16'h0, 16'h0};

  field_t      fresh [$];
  field_t      pending [$];
  item_t       plan [23];
  logic [7:0]  wr_code = 8'h00;
  int          sent = 0;
  int          errors = 0;
  int          quiet = 0;
  int          hold_len = 0;
  bit          idle_on = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic layout_t layout_of(input int s);
    layout_t r;
    case (s)
      0:       r = '{4'd6, FID_ACCEL, KIND_VEC};
      1:       r = '{4'd6, FID_ACCEL_G, KIND_VEC};
      2:       r = '{4'd6, FID_GYRO, KIND_VEC};
      3:       r = '{4'd6, FID_MAG, KIND_VEC};
      4:       r = '{4'd8, FID_TEMP, KIND_ENV};
      5:       r = '{4'd8, FID_QUAT, KIND_VEC};
      6:       r = '{4'd6, FID_EULER, KIND_VEC};
      7:       r = '{4'd6, FID_POSITION, KIND_VEC};
      8:       r = '{4'd5, FID_TIMESTAMP, KIND_SKIP};
      9:       r = '{4'd6, FID_TIMESTAMP, KIND_SKIP};
      10:      r = '{4'd2, FID_VOLTAGE, KIND_VOLT};
      default: r = '{4'd1, FID_TIMESTAMP, KIND_SKIP};
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] as_s16(input logic [15:0] x);
    logic signed [15:0] t;
    t = x;
    return t;
  endfunction

  function automatic logic signed [32:0] as_s24(input logic [23:0] x);
    logic signed [23:0] t;
    t = x;
    return t;
  endfunction

  function automatic item_t plain(input logic f, input logic [7:0] b, input logic e);
    return '{f, b, e, 1'b0, FID_TIMESTAMP, 33'sd0};
  endfunction

  task automatic note_field(input logic [4:0] id, input logic signed [32:0] v);
    if (fresh.size() < 4) fresh.push_back('{id, v, 1'b0});
  endtask

  // A byte past the header lands in the first enabled section at or after sec_at.
  task automatic section_byte(input logic [7:0] b);
    int s;
    int pos;
    int idx;
    layout_t lay;
    s = sec_at;
    while (s < 12 && !sub_tag[s]) s++;
    sec_at = s;
    if (s >= 12) return;
    lay = layout_of(s);
    case (lay.kind)
      KIND_VEC: begin
        pos = sec_pos % 2;
        acc |= {24'h0, b} << (8 * pos);
        if (pos == 1) begin
          idx = sec_pos / 2;
          note_field(lay.base + 5'(idx), as_s16(acc[15:0]));
          if (s == int'(EULER_SEC) && idx < 3) begin
            euler_now[idx] = acc[15:0];
            if (idx == 2) begin
              for (int k = 0; k < 3; k++)
                note_field(FID_EULER_COR + 5'(k), as_s16(euler_now[k]) - as_s16(euler_zero[k]));
            end
          end
          acc = 32'h0;
        end
      end
      KIND_ENV: begin
        if (sec_pos < 2) begin
          acc |= {24'h0, b} << (8 * sec_pos);
          if (sec_pos == 1) begin
            note_field(FID_TEMP, as_s16(acc[15:0]));
            acc = 32'h0;
          end
        end else begin
          pos = (sec_pos < 5) ? sec_pos - 2 : sec_pos - 5;
          acc |= {24'h0, b} << (8 * pos);
          if (pos == 2) begin
            note_field((sec_pos < 5) ? FID_PRESSURE : FID_HEIGHT, as_s24(acc[23:0]));
            acc = 32'h0;
          end
        end
      end
      KIND_VOLT: begin
        acc |= {24'h0, b} << (8 * (sec_pos % 2));
        if (sec_pos == 1) begin
          note_field(FID_VOLTAGE, {17'h0, acc[15:0]});
          acc = 32'h0;
        end
      end
      default: ;
    endcase
    if (sec_pos + 1 >= int'(lay.len)) begin
      sec_at = s + 1;
      sec_pos = 0;
    end else begin
      sec_pos = sec_pos + 1;
    end
  endtask

  // Advances the predictor by one accepted item and leaves its fields in fresh.
  task automatic parse_byte(input logic f, input logic [7:0] b, input logic e);
    int c;
    fresh.delete();
    if (f) begin
      for (int k = 0; k < 3; k++) euler_zero[k] = euler_now[k];
      return;
    end
    c = pkt_count;
    if (c == 0) begin
      pkt_ok = (b == code_p);
    end else if (c == 3) begin
      if (b != TYPE_BYTE) pkt_ok = 1'b0;
    end else if (pkt_ok && c >= 4) begin
      if (c == 4) begin
        sub_tag[7:0] = b;
        sec_at = 0;
        sec_pos = 0;
        acc = 32'h0;
      end else if (c == 5) begin
        sub_tag[15:8] = b;
      end else if (c <= 9) begin
        acc |= {24'h0, b} << (8 * (c - 6));
        if (c == 9) begin
          note_field(FID_TIMESTAMP, {1'b0, acc});
          acc = 32'h0;
        end
      end else begin
        section_byte(b);
      end
    end
    if (c < int'(COUNT_MAX)) pkt_count = c + 1;
    if (e) begin
      pkt_count = 0;
      pkt_ok = 1'b0;
      sec_at = 0;
      sec_pos = 0;
      acc = 32'h0;
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endtask

  // Called just after a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next call either keeps or drops it.
  task automatic push_byte(input item_t it);
    while (idle_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      in_func <= 1'($urandom);
      in_rx_byte <= 8'($urandom);
      in_end_of_packet <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= it.func;
    in_rx_byte <= it.data;
    in_end_of_packet <= it.eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    parse_byte(it.func, it.data, it.eop);
    if (it.typed) pending.push_back('{it.tid, it.tval, 1'b1});
    else foreach (fresh[i]) pending.push_back(fresh[i]);
    @(negedge clk);
  endtask

  task automatic write_code(input logic [7:0] v);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    // Items that make no result may still be in flight.
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_start_code <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    code_p = v;
    wr_code = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_report(input logic [15:0] tag, input pkt_shape_t shape);
    int total;
    int len;
    logic [7:0] b;
    layout_t lay;
    total = 10;
    for (int s = 0; s < 12; s++) begin
      if (tag[s]) begin
        lay = layout_of(s);
        total += int'(lay.len);
      end
    end
    case (shape)
      PKT_CUT:   len = $urandom_range(total - 1, 1);
      PKT_TRAIL: len = total + $urandom_range(6, 1);
      PKT_LONG:  len = 130 + $urandom_range(8, 0);
      default:   len = total;
    endcase
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0) begin
        if (shape == PKT_BAD_START) while (b == wr_code) b = 8'($urandom);
        else b = wr_code;
      end else if (i == 3) begin
        if (shape == PKT_BAD_TYPE) while (b == TYPE_BYTE) b = 8'($urandom);
        else b = TYPE_BYTE;
      end else if (i == 4) begin
        b = tag[7:0];
      end else if (i == 5) begin
        b = tag[15:8];
      end
      if ($urandom_range(99) < 3) push_byte(plain(1'b1, 8'($urandom), 1'($urandom)));
      push_byte(plain(1'b0, b, i == len - 1));
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len--;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 29);
      end
    end
  end

  always @(posedge clk) begin
    field_t exp_f;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, LIMIT);
        $display("imu_report_field_parser_core_tb NOT OK");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $display("%0t: unexpected field: expected none, got id %0d value %0d last %0b",
                   $time, out_field_id, out_field_value, out_last_of_run);
          errors++;
        end else begin
          exp_f = pending.pop_front();
          if (out_field_id !== exp_f.id || out_field_value !== exp_f.value ||
              out_last_of_run !== exp_f.last) begin
            $display("%0t: mismatch: expected id %0d value %0d last %0b, got id %0d value %0d last %0b",
                     $time, exp_f.id, exp_f.value, exp_f.last,
                     out_field_id, out_field_value, out_last_of_run);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int r;
    logic [15:0] tag;
    logic [7:0] code;
    pkt_shape_t shape;

    // Start code is zero after reset. Euler-only packet with extreme values,
    // then a capture, a wrong type byte and a wrong start code.
    plan = '{
      '{1'b0, 8'h00, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'hA5, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h5A, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h11, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h40, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h00, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'hFF, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'hFF, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'hFF, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'hFF, 1'b0, 1'b1, FID_TIMESTAMP, 33'sh0FFFFFFFF},
      '{1'b0, 8'h00, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h80, 1'b0, 1'b1, FID_EULER, -33'sd32768},
      '{1'b0, 8'hFF, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h7F, 1'b0, 1'b1, FID_EULER + 5'd1, 33'sd32767},
      '{1'b0, 8'h01, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h00, 1'b1, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b1, 8'h00, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h00, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h00, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h00, 1'b0, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h22, 1'b1, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b0, 8'h55, 1'b1, 1'b0, FID_TIMESTAMP, 33'sd0},
      '{1'b1, 8'hFF, 1'b1, 1'b0, FID_TIMESTAMP, 33'sd0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) push_byte(plan[i]);

    for (int p = 0; p < 5; p++) begin
      code = (p == 0) ? 8'hFF : (p == 4) ? 8'h00 : 8'($urandom);
      idle_on = (p != 2);
      write_code(code);
      if (p == 1) begin
        // Receiver holds off while Euler-heavy packets keep coming.
        hold_len = HOLD_CYCLES;
        repeat (3) send_report(16'h00E0, PKT_GOOD);
      end
      if (p == 3) send_report(16'($urandom), PKT_LONG);
      while (sent < 23 + (p + 1) * (TOTAL_ITEMS - 23) / 5) begin
        r = $urandom_range(99);
        if (r < 92) begin
          tag = 16'h0;
          repeat ($urandom_range(3, 1)) tag[$urandom_range(11, 0)] = 1'b1;
          if ($urandom_range(99) < 30) tag |= 16'h0040;
          if ($urandom_range(99) < 10) tag = 16'($urandom);
          shape = (r < 66) ? PKT_GOOD : (r < 76) ? PKT_CUT : (r < 84) ? PKT_TRAIL :
                  (r < 88) ? PKT_BAD_START : PKT_BAD_TYPE;
          send_report(tag, shape);
        end else begin
          // Noise burst, closed by an end of packet so the next packet lines up.
          r = $urandom_range(8, 1);
          for (int i = 0; i < r; i++)
            push_byte(plain(1'($urandom_range(9) == 0), 8'($urandom), i == r - 1));
        end
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0)
      $display("imu_report_field_parser_core_tb OK");
    else
      $display("imu_report_field_parser_core_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/imu_rfp_pkg.sv
src/imu_rfp_front.sv
src/imu_rfp_queue.sv
src/imu_rfp_back.sv
src/imu_report_field_parser_core.sv
src/imu_rfp_checker.sv
tb/imu_report_field_parser_core_tb.sv
